// ===== rtl/cpag_pkg.sv =====
// Shared types, constants and the waiter ordering function of the capped
// priority admission gate. Used by rtl/capped_priority_admission_gate.sv.
// Depends on nothing else.
package cpag_pkg;

    // Number of requester entries kept in the waiter store.
    localparam int REQUESTERS = 128;
    localparam int IDX_W      = $clog2(REQUESTERS);
    localparam int WCNT_W     = $clog2(REQUESTERS + 1);

    // Field widths of the stream beats.
    localparam int ID_W     = 7;
    localparam int PRIO_W   = 12;
    localparam int TICKET_W = 32;
    localparam int CNT_W    = 8;
    localparam int MODE_W   = 2;
    localparam int STAT_W   = 2;

    // Padded beat widths.
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // A cap register of zero acts as this cap.
    localparam logic [CNT_W-1:0] DEFAULT_CAP = 8'd2;

    // Configuration register indexes.
    localparam logic CFG_GATE_MODE = 1'b0;
    localparam logic CFG_SLOT_CAP  = 1'b1;

    // Event kinds carried in the input tuser bit.
    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF      = 2'd0,
        MODE_FIFO     = 2'd1,
        MODE_LOW_PRIO = 2'd2,
        MODE_HIGH_PRIO = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_ACCEPTED = 2'd0,
        STAT_IGNORED  = 2'd1,
        STAT_PASSED   = 2'd2
    } status_t;

    // One waiter entry as held in the waiter store.
    typedef struct packed {
        logic [PRIO_W-1:0]   prio;
        logic [TICKET_W-1:0] ticket;
    } waiter_t;

    // True when waiter a has to be admitted before waiter b.
    function automatic logic beats(mode_t mode, waiter_t a, waiter_t b);
        logic result;
        result = a.ticket < b.ticket;
        case (mode)
            MODE_LOW_PRIO:
            begin
                if (a.prio != b.prio)
                begin
                    result = a.prio < b.prio;
                end
            end
            MODE_HIGH_PRIO:
            begin
                if (a.prio != b.prio)
                begin
                    result = a.prio > b.prio;
                end
            end
            default:
            begin
                result = a.ticket < b.ticket;
            end
        endcase
        return result;
    endfunction

endpackage

// ===== rtl/cpag_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters. Depends on nothing else.
module cpag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/capped_priority_admission_gate.sv =====
// Capped priority admission gate: top level. Uses cpag_pkg for types and the
// ordering function, and one cpag_ram instance as the waiter store.
//
// The gate takes one acquire or release beat at a time and answers each with
// exactly one result beat. A beat that needs no search (off mode, an ignored
// duplicate or stray release, or a case with no free slot or no waiter) goes
// from acceptance straight to the finish state, which loads the result
// register. A beat that may admit a waiter walks the whole waiter store, one
// entry per cycle through the RAM's single read port, then admits the winner
// in the last state and loads the result in the finish state. The finish
// state waits only while the previous result beat is still held on the
// output side. The input is ready again in the cycle after the result is
// loaded, even while that result still waits on the output side, so a new
// beat can be accepted before the previous result is taken.
// No clearing pass is needed after reset: the waiting and holding flags live
// in flip-flops, and the store entries are only read for flagged waiters.
// Configuration writes must be made while the gate is idle.
module capped_priority_admission_gate (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // Event input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // requester_id[6:0], priority_req[18:7], zero pad
    input  logic        s_axis_tuser,   // command
    // Result output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // grant_valid[0], grant_id[7:1], event_status[9:8],
                                        // admitted_now[17:10], waiting_now[25:18], zero pad
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    cpag_pkg::mode_t                gate_mode_reg;
    logic [cpag_pkg::CNT_W-1:0]     slot_cap_reg;

    // Gate state kept in flip-flops.
    logic [cpag_pkg::TICKET_W-1:0]  ticket_reg, ticket_next;
    logic [cpag_pkg::CNT_W-1:0]     admitted_reg, admitted_next;
    logic [cpag_pkg::WCNT_W-1:0]    wcount_reg, wcount_next;
    logic [cpag_pkg::REQUESTERS-1:0] waiting_reg, waiting_next;
    logic [cpag_pkg::REQUESTERS-1:0] holding_reg, holding_next;

    // Search state.
    logic [cpag_pkg::IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                           rd_vld_reg;
    logic [cpag_pkg::IDX_W-1:0]     rd_idx_reg;
    logic                           found_reg, found_next;
    logic [cpag_pkg::IDX_W-1:0]     best_idx_reg, best_idx_next;
    cpag_pkg::waiter_t              best_reg, best_next;

    // Result under construction and output register.
    logic                           res_gv_reg, res_gv_next;
    logic [cpag_pkg::ID_W-1:0]      res_gid_reg, res_gid_next;
    cpag_pkg::status_t              res_stat_reg, res_stat_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [cpag_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Unpacked input fields.
    logic                           in_cmd;
    logic [cpag_pkg::ID_W-1:0]      in_id;
    logic [cpag_pkg::PRIO_W-1:0]    in_prio;
    logic [cpag_pkg::IDX_W-1:0]     in_idx;
    logic                           in_id_ok;
    logic                           accept;

    // Waiter store ports.
    logic                           ram_we;
    logic                           ram_re;
    cpag_pkg::waiter_t              ram_wdata;
    cpag_pkg::waiter_t              ram_rdata;

    logic [cpag_pkg::CNT_W-1:0]     eff_cap;
    logic [cpag_pkg::CNT_W-1:0]     adm_dec;
    logic                           cand_found;
    logic [cpag_pkg::IDX_W-1:0]     cand_idx;
    cpag_pkg::waiter_t              cand;

    assign in_cmd   = s_axis_tuser;
    assign in_id    = s_axis_tdata[6:0];
    assign in_prio  = s_axis_tdata[18:7];
    assign in_idx   = cpag_pkg::IDX_W'(in_id);
    assign in_id_ok = 32'(in_id) < cpag_pkg::REQUESTERS;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    assign eff_cap = (slot_cap_reg == '0) ? cpag_pkg::DEFAULT_CAP : slot_cap_reg;
    assign adm_dec = (admitted_reg == '0) ? '0 : admitted_reg - 1'b1;

    // A new waiter is written in its acceptance cycle; the walk reads later.
    assign ram_wdata.prio   = in_prio;
    assign ram_wdata.ticket = ticket_reg + 1'b1;
    assign ram_re           = (state_reg == ST_SCAN);

    cpag_ram #(
        .WIDTH ($bits(cpag_pkg::waiter_t)),
        .DEPTH (cpag_pkg::REQUESTERS)
    ) u_waiter_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    // Running best waiter, updated by the entry that returns from the store.
    // Ties in priority go to the lower ticket, that is the earlier acquire.
    always_comb
    begin
        cand_found = found_reg;
        cand_idx   = best_idx_reg;
        cand       = best_reg;
        if (rd_vld_reg && waiting_reg[rd_idx_reg])
        begin
            if (!found_reg || cpag_pkg::beats(gate_mode_reg, ram_rdata, best_reg))
            begin
                cand_found = 1'b1;
                cand_idx   = rd_idx_reg;
                cand       = ram_rdata;
            end
        end
    end

    // Event handling, search sequencing and result loading.
    always_comb
    begin
        state_next    = state_reg;
        ticket_next   = ticket_reg;
        admitted_next = admitted_reg;
        wcount_next   = wcount_reg;
        waiting_next  = waiting_reg;
        holding_next  = holding_reg;
        scan_idx_next = scan_idx_reg;
        found_next    = cand_found;
        best_idx_next = cand_idx;
        best_next     = cand;
        res_gv_next   = res_gv_reg;
        res_gid_next  = res_gid_reg;
        res_stat_next = res_stat_reg;
        m_tvalid_next = m_tvalid_reg && !m_axis_tready;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_gv_next   = 1'b0;
                    res_gid_next  = '0;
                    res_stat_next = cpag_pkg::STAT_ACCEPTED;
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    state_next    = ST_FINISH;
                    if (gate_mode_reg == cpag_pkg::MODE_OFF)
                    begin
                        res_stat_next = cpag_pkg::STAT_PASSED;
                        if (in_cmd == cpag_pkg::CMD_ACQUIRE)
                        begin
                            res_gv_next  = 1'b1;
                            res_gid_next = in_id;
                        end
                    end
                    else if (!in_id_ok)
                    begin
                        res_stat_next = cpag_pkg::STAT_IGNORED;
                    end
                    else if (in_cmd == cpag_pkg::CMD_ACQUIRE)
                    begin
                        if (holding_reg[in_idx] || waiting_reg[in_idx])
                        begin
                            res_stat_next = cpag_pkg::STAT_IGNORED;
                        end
                        else
                        begin
                            ram_we               = 1'b1;
                            ticket_next          = ticket_reg + 1'b1;
                            waiting_next[in_idx] = 1'b1;
                            wcount_next          = wcount_reg + 1'b1;
                            if (admitted_reg < eff_cap)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                    end
                    else
                    begin
                        if (!holding_reg[in_idx])
                        begin
                            res_stat_next = cpag_pkg::STAT_IGNORED;
                        end
                        else
                        begin
                            holding_next[in_idx] = 1'b0;
                            admitted_next        = adm_dec;
                            if (adm_dec < eff_cap && wcount_reg != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (scan_idx_reg == cpag_pkg::IDX_W'(cpag_pkg::REQUESTERS - 1))
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            ST_LAST:
            begin
                // The last entry is in the running best; admit the winner.
                if (cand_found)
                begin
                    waiting_next[cand_idx] = 1'b0;
                    holding_next[cand_idx] = 1'b1;
                    admitted_next          = admitted_reg + 1'b1;
                    wcount_next            = wcount_reg - 1'b1;
                    res_gv_next            = 1'b1;
                    res_gid_next           = cpag_pkg::ID_W'(cand_idx);
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, cpag_pkg::CNT_W'(wcount_reg), admitted_reg,
                                     res_stat_reg, res_gid_reg, res_gv_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, configuration and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gate_mode_reg <= cpag_pkg::MODE_OFF;
            slot_cap_reg  <= cpag_pkg::DEFAULT_CAP;
            ticket_reg    <= '0;
            admitted_reg  <= '0;
            wcount_reg    <= '0;
            waiting_reg   <= '0;
            holding_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ticket_reg   <= ticket_next;
            admitted_reg <= admitted_next;
            wcount_reg   <= wcount_next;
            waiting_reg  <= waiting_next;
            holding_reg  <= holding_next;
            rd_vld_reg   <= ram_re;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    cpag_pkg::CFG_GATE_MODE:
                    begin
                        gate_mode_reg <= cpag_pkg::mode_t'(cfg_data[1:0]);
                    end
                    cpag_pkg::CFG_SLOT_CAP:
                    begin
                        slot_cap_reg <= cfg_data;
                    end
                    default:
                    begin
                        slot_cap_reg <= slot_cap_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers of the search and the result.
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        rd_idx_reg   <= scan_idx_reg;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        res_gv_reg   <= res_gv_next;
        res_gid_reg  <= res_gid_next;
        res_stat_reg <= res_stat_next;
    end

endmodule
